// ===== hdl/sxlt_pkg.sv =====
// Types shared by the shared/exclusive unit lock table.
`default_nettype none
package sxlt_pkg;

  localparam int unsigned CfgCount = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CapW     = 16;
  localparam int unsigned UnitsW   = 16;
  localparam int unsigned SlotW    = 3;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_BUSY     = 3'd1,
    ST_ZERO     = 3'd2,
    ST_CONFLICT = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  typedef enum logic {
    KIND_ACQUIRE = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_e;

endpackage
`default_nettype wire

// ===== hdl/shared_exclusive_unit_lock_table.sv =====
// Shared/exclusive unit lock table with per-request claim aggregation.
//
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_stall_o   | kind, slot, exclusive, write_claim, units, last
// out     | output    | out_valid_o / out_stall_i | status
// cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// Each word is processed in the cycle it is accepted; one word per cycle unless the input stalls.
// A result is written into the output register when the last acquire claim is accepted.
// The input stalls only while a result waits in the output register and the output is stalled.
// Reset clears all held, pending and capacity state at once; there is no clearing pass.
`default_nettype none
module shared_exclusive_unit_lock_table #(
  parameter int unsigned SLOT_COUNT = 8,
  parameter int unsigned UNIT_BITS  = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          kind_i,
  input  wire logic [sxlt_pkg::SlotW-1:0]    slot_i,
  input  wire logic                          exclusive_i,
  input  wire logic                          write_claim_i,
  input  wire logic [sxlt_pkg::UnitsW-1:0]   units_i,
  input  wire logic                          last_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         status_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [sxlt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [sxlt_pkg::CapW-1:0]     cfg_wdata_i
);
  import sxlt_pkg::*;

  localparam int unsigned BaseW = (UNIT_BITS > CapW) ? UNIT_BITS : CapW;
  localparam int unsigned XW = BaseW + 1;
  localparam logic [XW-1:0] UnitMask = XW'({UNIT_BITS{1'b1}});

  logic [CapW-1:0]      cap_q     [SLOT_COUNT];
  logic [UNIT_BITS-1:0] held_q    [SLOT_COUNT];
  logic [UNIT_BITS-1:0] held_d    [SLOT_COUNT];
  logic [UNIT_BITS-1:0] pend_q    [SLOT_COUNT];
  logic [UNIT_BITS-1:0] pend_d    [SLOT_COUNT];
  logic [UNIT_BITS-1:0] pend_n    [SLOT_COUNT];
  logic [XW-1:0]        tot_x     [SLOT_COUNT];
  logic [XW-1:0]        cap_x     [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] exh_q, exh_d;
  logic [SLOT_COUNT-1:0] seen_q, seen_d, seen_n;
  logic [SLOT_COUNT-1:0] pex_q, pex_d, pex_n;
  logic [SLOT_COUNT-1:0] hit, busy, mixed;
  status_e err_q, err_d, err_new, claim_err, fin_status;
  status_e status_q, status_d;
  logic out_valid_q, out_valid_d;

  logic          acc;
  logic          excl;
  logic          slot_ok;
  logic          claim_upd;
  logic          sel_seen;
  logic          sel_pex;
  logic [XW-1:0] sel_pend_x;
  logic [XW-1:0] units_x;
  logic [XW-1:0] sum_x;
  logic [XW-1:0] rel_x;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign acc         = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

  always_comb begin
    excl       = exclusive_i | write_claim_i;
    slot_ok    = {1'b0, slot_i} < 4'(SLOT_COUNT);
    units_x    = XW'(units_i);
    sel_seen   = 1'b0;
    sel_pex    = 1'b0;
    sel_pend_x = '0;
    for (int j = 0; j < SLOT_COUNT; j++) begin
      hit[j] = slot_ok && (slot_i == SlotW'(j));
      if (hit[j]) begin
        sel_seen   = seen_q[j];
        sel_pex    = pex_q[j];
        sel_pend_x = XW'(pend_q[j]);
      end
    end
    sum_x     = sel_pend_x + units_x;
    claim_err = ST_GRANTED;
    claim_upd = 1'b0;
    if (err_q == ST_GRANTED && slot_ok) begin
      if (units_i == '0) begin
        claim_err = ST_ZERO;
      end else if (sel_seen) begin
        if (sel_pex != excl || excl) begin
          claim_err = ST_CONFLICT;
        end else if (sum_x > UnitMask) begin
          claim_err = ST_OVERFLOW;
        end else begin
          claim_upd = 1'b1;
        end
      end else if (units_x > UnitMask) begin
        claim_err = ST_OVERFLOW;
      end else begin
        claim_upd = 1'b1;
      end
    end
    err_new = (err_q != ST_GRANTED) ? err_q : claim_err;

    for (int j = 0; j < SLOT_COUNT; j++) begin
      seen_n[j] = seen_q[j] | (claim_upd & hit[j]);
      pex_n[j]  = (claim_upd & hit[j]) ? excl : pex_q[j];
      pend_n[j] = (claim_upd & hit[j]) ? UNIT_BITS'(sum_x) : pend_q[j];
      tot_x[j]  = XW'(held_q[j]) + XW'(pend_n[j]);
      cap_x[j]  = (XW'(cap_q[j]) > UnitMask) ? UnitMask : XW'(cap_q[j]);
      if (pex_n[j]) begin
        busy[j] = seen_n[j] && (exh_q[j] || held_q[j] != '0);
      end else begin
        busy[j] = seen_n[j] && (exh_q[j] || tot_x[j] > cap_x[j]);
      end
      mixed[j] = exh_q[j] && held_q[j] != '0;
    end
    if (err_new != ST_GRANTED) begin
      fin_status = err_new;
    end else if (|busy) begin
      fin_status = ST_BUSY;
    end else begin
      fin_status = ST_GRANTED;
    end

    exh_d       = exh_q;
    seen_d      = seen_q;
    pex_d       = pex_q;
    err_d       = err_q;
    held_d      = held_q;
    pend_d      = pend_q;
    rel_x       = '0;
    status_d    = status_q;
    out_valid_d = out_valid_q & out_stall_i;

    if (acc) begin
      if (kind_i == KIND_RELEASE) begin
        for (int j = 0; j < SLOT_COUNT; j++) begin
          if (hit[j]) begin
            rel_x = XW'(held_q[j]) - units_x;
            if (excl) begin
              exh_d[j] = 1'b0;
            end else if (XW'(held_q[j]) >= units_x) begin
              held_d[j] = UNIT_BITS'(rel_x);
            end else begin
              held_d[j] = '0;
            end
          end
        end
      end else if (last_i) begin
        out_valid_d = 1'b1;
        status_d    = fin_status;
        if (fin_status == ST_GRANTED) begin
          for (int j = 0; j < SLOT_COUNT; j++) begin
            if (seen_n[j]) begin
              if (pex_n[j]) begin
                exh_d[j] = 1'b1;
              end else begin
                held_d[j] = UNIT_BITS'(tot_x[j]);
              end
            end
          end
        end
        seen_d = '0;
        pex_d  = '0;
        err_d  = ST_GRANTED;
        for (int j = 0; j < SLOT_COUNT; j++) begin
          pend_d[j] = '0;
        end
      end else begin
        seen_d = seen_n;
        pex_d  = pex_n;
        pend_d = pend_n;
        err_d  = err_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < SLOT_COUNT; j++) begin
        cap_q[j]  <= '0;
        held_q[j] <= '0;
        pend_q[j] <= '0;
      end
      exh_q       <= '0;
      seen_q      <= '0;
      pex_q       <= '0;
      err_q       <= ST_GRANTED;
      status_q    <= ST_GRANTED;
      out_valid_q <= 1'b0;
    end else begin
      for (int j = 0; j < SLOT_COUNT; j++) begin
        if (cfg_we_i && cfg_idx_i == CfgIdxW'(j)) begin
          cap_q[j] <= cfg_wdata_i;
        end
      end
      held_q      <= held_d;
      pend_q      <= pend_d;
      exh_q       <= exh_d;
      seen_q      <= seen_d;
      pex_q       <= pex_d;
      err_q       <= err_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_no_mixed_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mixed == '0)
    else $error("Slot holds exclusive and shared units at once.");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(acc && kind_i == KIND_ACQUIRE && last_i))
    else $error("Result appeared without a last acquire claim.");

  a_request_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && kind_i == KIND_ACQUIRE && last_i) |=> (err_q == ST_GRANTED && seen_q == '0))
    else $error("Pending request not cleared after its last claim.");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("Input stalled with an empty result register.");

endmodule
`default_nettype wire
